// ===== rtl/newton_sine_warp_inverse_macros.svh =====
// assertion helpers shared by the rtl
`ifndef NEWTON_SINE_WARP_INVERSE_MACROS_SVH
`define NEWTON_SINE_WARP_INVERSE_MACROS_SVH

// checked only while out of reset
`define NSWI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define NSWI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nswi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nswi_pkg
// Types and fixed constants of the sine warp inverse solver.
// ----------------------------------------------------------------------------
package nswi_pkg;

    localparam int FRAC_BITS = 28;
    localparam int THR_W     = 10;
    localparam int QUOT_BITS = 33;
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;

    // operation codes
    localparam logic OP_PERIOD1 = 1'b0;
    localparam logic OP_PERIOD2 = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET   = 10'd16;
    localparam logic [31:0]      PI_Q30      = 32'd3373259426;
    localparam logic [28:0]      INV_2PI_Q30 = 29'd170891319;
    localparam logic [28:0]      INV_PI_Q30  = 29'd341782638;
    localparam logic signed [31:0] Q30_ONE   = 32'sd1073741824;
    localparam logic signed [31:0] X_MAX     = 32'sh7fffffff;
    localparam logic signed [31:0] X_MIN     = 32'sh80000000;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        logic op;
        t_q   a;
        t_q   b;
        t_q   x;
        logic fault;
        logic skip;
    } t_ctx;

    // horner divisors, innermost first
    function automatic int f_sin_k(input int j);
        int k;
        unique case (j)
            0:       k = 110;
            1:       k = 72;
            2:       k = 42;
            3:       k = 20;
            default: k = 6;
        endcase
        return k;
    endfunction

    function automatic int f_cos_k(input int j);
        int k;
        unique case (j)
            0:       k = 132;
            1:       k = 90;
            2:       k = 56;
            3:       k = 30;
            4:       k = 12;
            default: k = 2;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/nswi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nswi_if
// Valid/ready channels for solver requests and solutions.
// ----------------------------------------------------------------------------
interface nswi_in_if;
    logic              valid;
    logic              ready;
    logic              operation;
    logic signed [31:0] target_value;
    logic signed [31:0] warp_strength;

    modport source (output valid, operation, target_value, warp_strength, input ready);
    modport sink   (input valid, operation, target_value, warp_strength, output ready);
endinterface

interface nswi_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] solution;
    logic              divide_fault;

    modport source (output valid, solution, divide_fault, input ready);
    modport sink   (input valid, solution, divide_fault, output ready);
endinterface

// ===== rtl/nswi_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nswi_sincos
// Pipelined sine and cosine of w*x, Q30, Taylor series in Horner form.
// ----------------------------------------------------------------------------
module nswi_sincos (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_vld,
    input  nswi_pkg::t_ctx      i_ctx,
    output logic                o_vld,
    output nswi_pkg::t_ctx      o_ctx,
    output logic signed [31:0]  o_sin,
    output logic signed [31:0]  o_cos
);

    localparam int NST   = nswi_pkg::COS_TERMS;
    localparam int PH_SH = 32 - nswi_pkg::FRAC_BITS;
    localparam logic signed [32:0] R_QTR  = 33'sd1073741824;
    localparam logic signed [32:0] R_HALF = 33'sd2147483648;

    // phase fold and scale to radians
    logic [31:0]        w_p;
    logic signed [32:0] w_r;
    logic               w_neg;
    logic signed [65:0] w_pp;

    always_comb begin
        w_p   = (i_ctx.op == nswi_pkg::OP_PERIOD2) ? (i_ctx.x << (PH_SH - 1))
                                                   : (i_ctx.x << PH_SH);
        w_r   = {w_p[31], w_p};
        w_neg = 1'b0;
        if (w_r > R_QTR) begin
            w_r   = w_r - R_HALF;
            w_neg = 1'b1;
        end else if (w_r < -R_QTR) begin
            w_r   = w_r + R_HALF;
            w_neg = 1'b1;
        end
    end

    assign w_pp = w_r * $signed({1'b0, nswi_pkg::PI_Q30});

    logic               r1_vld;
    nswi_pkg::t_ctx     r1_ctx;
    logic signed [31:0] r1_xr;
    logic               r1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ctx <= i_ctx;
            r1_xr  <= w_pp[62:31];
            r1_neg <= w_neg;
        end
    end

    // square of the angle
    logic signed [63:0] w_sq;
    logic               r2_vld;
    nswi_pkg::t_ctx     r2_ctx;
    logic signed [31:0] r2_xr;
    logic [31:0]        r2_x2;
    logic               r2_neg;

    assign w_sq = r1_xr * r1_xr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_ctx <= r1_ctx;
            r2_xr  <= r1_xr;
            r2_x2  <= w_sq[61:30];
            r2_neg <= r1_neg;
        end
    end

    // horner steps, lane 0 cosine, lane 1 sine
    logic               s_vld [NST+1];
    nswi_pkg::t_ctx     s_ctx [NST+1];
    logic signed [31:0] s_xr  [NST+1];
    logic [31:0]        s_x2  [NST];
    logic               s_neg [NST+1];
    logic signed [31:0] s_t   [2][NST+1];

    assign s_vld[0]  = r2_vld;
    assign s_ctx[0]  = r2_ctx;
    assign s_xr[0]   = r2_xr;
    assign s_x2[0]   = r2_x2;
    assign s_neg[0]  = r2_neg;
    assign s_t[0][0] = nswi_pkg::Q30_ONE;
    assign s_t[1][0] = nswi_pkg::Q30_ONE;

    for (genvar j = 0; j < NST; j++) begin : g_step
        logic               r_v  [3];
        nswi_pkg::t_ctx     r_c  [3];
        logic signed [31:0] r_xr [3];
        logic               r_ng [3];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[0] <= 1'b0;
                r_v[1] <= 1'b0;
                r_v[2] <= 1'b0;
            end else if (i_adv) begin
                r_v[0] <= s_vld[j];
                r_v[1] <= r_v[0];
                r_v[2] <= r_v[1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_c[0]  <= s_ctx[j];
                r_c[1]  <= r_c[0];
                r_c[2]  <= r_c[1];
                r_xr[0] <= s_xr[j];
                r_xr[1] <= r_xr[0];
                r_xr[2] <= r_xr[1];
                r_ng[0] <= s_neg[j];
                r_ng[1] <= r_ng[0];
                r_ng[2] <= r_ng[1];
            end
        end

        assign s_vld[j+1] = r_v[2];
        assign s_ctx[j+1] = r_c[2];
        assign s_xr[j+1]  = r_xr[2];
        assign s_neg[j+1] = r_ng[2];

        if (j < NST - 1) begin : g_x2
            logic [31:0] r_x2 [3];
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_x2[0] <= s_x2[j];
                    r_x2[1] <= r_x2[0];
                    r_x2[2] <= r_x2[1];
                end
            end
            assign s_x2[j+1] = r_x2[2];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            localparam int TERMS = (l == 0) ? nswi_pkg::COS_TERMS : nswi_pkg::SIN_TERMS;
            if (j < TERMS) begin : g_act
                localparam int K = (l == 0) ? nswi_pkg::f_cos_k(j) : nswi_pkg::f_sin_k(j);
                localparam logic [31:0] RC = 32'((64'd1 << 32) / K);
                localparam logic [31:0] KV = 32'(K);

                logic [62:0]        w_mp;
                logic [63:0]        w_rp;
                logic [31:0]        w_rem;
                logic [31:0]        w_q;
                logic [31:0]        r_ma;
                logic [31:0]        r_mb;
                logic [31:0]        r_q0;
                logic signed [31:0] r_t;

                // terms stay positive ahead of the last step, so floor equals truncation
                assign w_mp  = s_x2[j] * s_t[l][j][30:0];
                assign w_rp  = r_ma * RC;
                assign w_rem = r_mb - r_q0 * KV;
                assign w_q   = (w_rem >= KV) ? r_q0 + 32'd1 : r_q0;

                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_ma <= w_mp[61:30];
                        r_mb <= r_ma;
                        r_q0 <= w_rp[63:32];
                        r_t  <= nswi_pkg::Q30_ONE - $signed(w_q);
                    end
                end

                assign s_t[l][j+1] = r_t;
            end else begin : g_pass
                logic signed [31:0] r_d [3];
                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_d[0] <= s_t[l][j];
                        r_d[1] <= r_d[0];
                        r_d[2] <= r_d[1];
                    end
                end
                assign s_t[l][j+1] = r_d[2];
            end
        end
    end

    // final sine product and sign of the folded half turn
    logic signed [63:0] w_sp;
    logic signed [31:0] w_sv;

    assign w_sp = s_xr[NST] * s_t[1][NST];
    assign w_sv = w_sp[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= s_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_ctx <= s_ctx[NST];
            o_sin <= s_neg[NST] ? -w_sv : w_sv;
            o_cos <= s_neg[NST] ? -s_t[0][NST] : s_t[0][NST];
        end
    end

endmodule

// ===== rtl/nswi_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nswi_step
// One pipelined Newton step: residual, slope and restoring divide.
// ----------------------------------------------------------------------------
module nswi_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  nswi_pkg::t_ctx i_ctx,
    output logic           o_vld,
    output nswi_pkg::t_ctx o_ctx
);

    localparam int QB = nswi_pkg::QUOT_BITS;
    localparam int FB = nswi_pkg::FRAC_BITS;
    localparam int NB = QB - FB;          // quotient bits fed from the numerator
    localparam logic signed [33:0] DEN_ONE = 34'sd1 <<< FB;

    logic               w_sc_vld;
    nswi_pkg::t_ctx     w_sc_ctx;
    logic signed [31:0] w_sin;
    logic signed [31:0] w_cos;

    nswi_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (i_adv),
        .i_vld   (i_vld),
        .i_ctx   (i_ctx),
        .o_vld   (w_sc_vld),
        .o_ctx   (w_sc_ctx),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // b*sin and b*cos
    logic signed [63:0] w_bs;
    logic signed [63:0] w_bc;
    logic               r1_vld;
    nswi_pkg::t_ctx     r1_ctx;
    logic signed [32:0] r1_bs;
    logic signed [32:0] r1_bc;

    assign w_bs = w_sc_ctx.b * w_sin;
    assign w_bc = w_sc_ctx.b * w_cos;

    // scale by 1/w, form the slope
    logic [28:0]        w_inv;
    logic signed [62:0] w_tp;
    logic               r2_vld;
    nswi_pkg::t_ctx     r2_ctx;
    logic signed [31:0] r2_tw;
    logic signed [33:0] r2_den;

    assign w_inv = (r1_ctx.op == nswi_pkg::OP_PERIOD2) ? nswi_pkg::INV_PI_Q30
                                                      : nswi_pkg::INV_2PI_Q30;
    assign w_tp  = r1_bs * $signed({1'b0, w_inv});

    // residual, magnitudes, zero slope
    logic signed [34:0] w_num;
    logic [33:0]        w_n;
    logic [33:0]        w_d;
    logic               w_dz;
    nswi_pkg::t_ctx     w_c3;
    logic               r3_vld;
    nswi_pkg::t_ctx     r3_ctx;
    logic [33:0]        r3_n;
    logic [33:0]        r3_d;
    logic               r3_ng;

    always_comb begin
        w_num = 35'(r2_ctx.x) + 35'(r2_tw) - 35'(r2_ctx.a);
        w_n   = w_num[34] ? 34'(-w_num) : w_num[33:0];
        w_d   = r2_den[33] ? -r2_den : r2_den;
        w_dz  = (r2_den == '0);
        w_c3  = r2_ctx;
        if (!r2_ctx.skip && w_dz) begin
            w_c3.x     = w_num[34] ? nswi_pkg::X_MAX : nswi_pkg::X_MIN;
            w_c3.fault = 1'b1;
            w_c3.skip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= w_sc_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ctx <= w_sc_ctx;
            r1_bs  <= w_bs[62:30];
            r1_bc  <= w_bc[62:30];
            r2_ctx <= r1_ctx;
            r2_tw  <= w_tp[61:30];
            r2_den <= {r1_bc[32], r1_bc} + DEN_ONE;
            r3_ctx <= w_c3;
            r3_n   <= w_n;
            r3_d   <= w_d;
            r3_ng  <= w_num[34] ^ r2_den[33];
        end
    end

    // divider head: quotient cap and first partial remainder
    logic           d_vld [QB+1];
    nswi_pkg::t_ctx d_ctx [QB+1];
    logic [QB-1:0]  d_q   [QB+1];
    logic           d_ovf [QB+1];
    logic           d_ng  [QB+1];
    logic [33:0]    d_rem [QB];
    logic [33:0]    d_d   [QB];
    logic [33:0]    d_n   [NB];

    logic           r4_vld;
    nswi_pkg::t_ctx r4_ctx;
    logic           r4_ovf;
    logic           r4_ng;
    logic [33:0]    r4_rem;
    logic [33:0]    r4_d;
    logic [33:0]    r4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_ctx <= r3_ctx;
            r4_ovf <= {5'd0, r3_n} >= {r3_d, 5'd0};
            r4_ng  <= r3_ng;
            r4_rem <= r3_n >> NB;
            r4_d   <= r3_d;
            r4_n   <= r3_n;
        end
    end

    assign d_vld[0] = r4_vld;
    assign d_ctx[0] = r4_ctx;
    assign d_q[0]   = '0;
    assign d_ovf[0] = r4_ovf;
    assign d_ng[0]  = r4_ng;
    assign d_rem[0] = r4_rem;
    assign d_d[0]   = r4_d;
    assign d_n[0]   = r4_n;

    // one quotient bit a stage, most significant first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BI = QB - 1 - k;

        logic           w_bit;
        logic [34:0]    w_sh;
        logic           w_ge;
        logic           r_v;
        nswi_pkg::t_ctx r_c;
        logic [QB-1:0]  r_q;
        logic           r_ovf;
        logic           r_ng;

        if (BI >= FB) begin : g_nbit
            assign w_bit = d_n[k][BI-FB];
        end else begin : g_zbit
            assign w_bit = 1'b0;
        end

        assign w_sh = {d_rem[k], w_bit};
        assign w_ge = w_sh >= {1'b0, d_d[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= d_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_c   <= d_ctx[k];
                r_q   <= {d_q[k][QB-2:0], w_ge};
                r_ovf <= d_ovf[k];
                r_ng  <= d_ng[k];
            end
        end

        assign d_vld[k+1] = r_v;
        assign d_ctx[k+1] = r_c;
        assign d_q[k+1]   = r_q;
        assign d_ovf[k+1] = r_ovf;
        assign d_ng[k+1]  = r_ng;

        if (k < QB - 1) begin : g_fwd
            logic [33:0] r_rem;
            logic [33:0] r_d;
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem <= w_ge ? 34'(w_sh - {1'b0, d_d[k]}) : w_sh[33:0];
                    r_d   <= d_d[k];
                end
            end
            assign d_rem[k+1] = r_rem;
            assign d_d[k+1]   = r_d;
        end

        if (k < NB - 1) begin : g_nfwd
            logic [33:0] r_n;
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_n <= d_n[k];
                end
            end
            assign d_n[k+1] = r_n;
        end
    end

    // apply the step and saturate
    logic [33:0]        w_qv;
    logic signed [35:0] w_xs;
    logic signed [35:0] w_xn;
    nswi_pkg::t_ctx     w_co;

    always_comb begin
        w_qv = d_ovf[QB] ? (34'd1 << QB) : {1'b0, d_q[QB]};
        w_xs = 36'(d_ctx[QB].x);
        w_xn = d_ng[QB] ? w_xs + $signed({2'b00, w_qv}) : w_xs - $signed({2'b00, w_qv});
        w_co = d_ctx[QB];
        if (!d_ctx[QB].skip) begin
            if (w_xn > 36'(nswi_pkg::X_MAX)) begin
                w_co.x = nswi_pkg::X_MAX;
            end else if (w_xn < 36'(nswi_pkg::X_MIN)) begin
                w_co.x = nswi_pkg::X_MIN;
            end else begin
                w_co.x = w_xn[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= d_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_ctx <= w_co;
        end
    end

endmodule

// ===== rtl/newton_sine_warp_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_sine_warp_inverse
// Solves x + (b/w)*sin(w*x) = a by a fixed count of Newton steps from x = a.
// ----------------------------------------------------------------------------
// One request beat is taken every cycle while the output is not stalled, and one
// solution beat leaves per request, in order. Each request passes one input
// register, then for each Newton step 21 stages of sine/cosine, four stages of
// products, slope, residual and divider head, a 33-stage restoring divider at
// one quotient bit a stage and the step's output register. The whole pipeline
// holds while a finished solution waits on the output, so ready follows the
// output side combinationally.
// ----------------------------------------------------------------------------
`include "newton_sine_warp_inverse_macros.svh"

module newton_sine_warp_inverse #(
    parameter int NEWTON_STEPS = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    nswi_in_if.sink                      i_in,
    nswi_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [nswi_pkg::THR_W-1:0]   i_cfg_wdata
);

    logic [nswi_pkg::THR_W-1:0] r_thr;
    logic                       w_adv;
    logic [32:0]                w_bx;
    logic [32:0]                w_bmag;
    nswi_pkg::t_ctx             w_in_ctx;
    logic                       r_in_vld;
    nswi_pkg::t_ctx             r_in_ctx;
    logic                       s_vld [NEWTON_STEPS+1];
    nswi_pkg::t_ctx             s_ctx [NEWTON_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= nswi_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // small strength passes the target straight through
    always_comb begin
        w_bx           = {i_in.warp_strength[31], i_in.warp_strength};
        w_bmag         = w_bx[32] ? -w_bx : w_bx;
        w_in_ctx.op    = i_in.operation;
        w_in_ctx.a     = i_in.target_value;
        w_in_ctx.b     = i_in.warp_strength;
        w_in_ctx.x     = i_in.target_value;
        w_in_ctx.fault = 1'b0;
        w_in_ctx.skip  = w_bmag < {{(33 - nswi_pkg::THR_W){1'b0}}, r_thr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_ctx <= w_in_ctx;
        end
    end

    assign s_vld[0] = r_in_vld;
    assign s_ctx[0] = r_in_ctx;

    for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_newton
        nswi_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (s_vld[g]),
            .i_ctx   (s_ctx[g]),
            .o_vld   (s_vld[g+1]),
            .o_ctx   (s_ctx[g+1])
        );
    end

    // the last step's registers are the output register
    assign o_out.valid        = s_vld[NEWTON_STEPS];
    assign o_out.solution     = s_ctx[NEWTON_STEPS].x;
    assign o_out.divide_fault = s_ctx[NEWTON_STEPS].fault;

    `NSWI_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |-> !i_in.ready, "input taken while output beat stalled")
    `NSWI_ASSERT(a_fault_saturates, i_clk, i_rst_n, (o_out.valid && o_out.divide_fault) |-> (o_out.solution == nswi_pkg::X_MAX || o_out.solution == nswi_pkg::X_MIN), "fault without saturated solution")
    `NSWI_ASSERT(a_cfg_write, i_clk, i_rst_n, i_cfg_we |=> (r_thr == $past(i_cfg_wdata)), "threshold write lost")
    `NSWI_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!o_out.valid && !r_in_vld), "pipeline not empty after reset")

endmodule
